// ----- rtl/lpr_pkg.sv -----
// Shared types and constants for the line pixel rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  localparam int COORD_BITS   = 12;
  localparam int COLOR_BITS   = 16;
  // Error term spans minus to plus the largest extent.
  localparam int ERR_BITS     = COORD_BITS + 2;
  localparam int REG_BITS     = 12;
  localparam int CFG_IDX_BITS = 1;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RST  = REG_BITS'(320);
  localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RST = REG_BITS'(240);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_e;

  typedef struct packed {
    func_e  func;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t line_color;
  } line_cmd_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   inside_res;
    logic   last;
  } pixel_t;

endpackage

`default_nettype wire

// ----- rtl/line_pixel_rasterizer_top.sv -----
// Top level of the line pixel rasterizer: stream ports, config, result register.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: start_x,start_y,end_x,end_y,line_color
//                                              tuser: func
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pixel_x,pixel_y,pixel_color
//                                              tuser: inside_res, tlast: last
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
//  One item per cycle unless m_axis stalls: line state, step logic, one result register.
//  A pixel appears on m_axis the cycle after its step item is accepted; loads give none.
//  s_axis_tready is high whenever the result register is empty or is being drained.
//  Reset clears the line (no line active) and sets the screen to 320 x 240.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_rasterizer_top import lpr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x, start_y, end_x, end_y, line_color (lowest bit up)
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // func
  input  wire logic                     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // pixel_x, pixel_y, pixel_color (lowest bit up)
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  // inside_res
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [REG_BITS-1:0]      cfg_wdata_i
);

  logic [REG_BITS-1:0] screen_w_q, screen_h_q;
  logic                out_valid_q, out_valid_d;
  pixel_t              out_q;
  line_cmd_t           cmd;
  logic                in_acc;
  logic                res_valid;
  pixel_t              res;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.func       = func_e'(s_axis_tuser);
    cmd.start_x    = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    cmd.start_y    = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    cmd.end_x      = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    cmd.end_y      = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    cmd.line_color = s_axis_tdata[4*COORD_BITS +: COLOR_BITS];
  end

  lpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .cmd_i       (cmd),
    .screen_w_i  (screen_w_q),
    .screen_h_i  (screen_h_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= SCREEN_WIDTH_RST;
      screen_h_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCREEN_WIDTH:  screen_w_q <= cfg_wdata_i;
        REG_SCREEN_HEIGHT: screen_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload loads only with a fresh pixel; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({out_q.pixel_color, out_q.pixel_y, out_q.pixel_x});
  assign m_axis_tuser  = out_q.inside_res;
  assign m_axis_tlast  = out_q.last;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_load_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == FUNC_LOAD) |=> !m_axis_tvalid)
    else $error("load item produced a pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready)
      |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
           && $stable(m_axis_tlast)))
    else $error("result item changed while stalled");

endmodule

`default_nettype wire

// ----- rtl/lpr_core.sv -----
// Bresenham line state and per-item step logic.
`timescale 1ns / 1ps
`default_nettype none

module lpr_core import lpr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                acc_i,
  input  wire line_cmd_t           cmd_i,
  input  wire logic [REG_BITS-1:0] screen_w_i,
  input  wire logic [REG_BITS-1:0] screen_h_i,
  output logic                     res_valid_o,
  output pixel_t                   res_o
);

  coord_t                cur_x_q, cur_x_d;
  coord_t                cur_y_q, cur_y_d;
  coord_t                major_end_q, major_end_d;
  coord_t                abs_dx_q, abs_dx_d;
  coord_t                abs_dy_q, abs_dy_d;
  logic [ERR_BITS-1:0]   err_q, err_d;
  logic                  x_neg_q, x_neg_d;
  logic                  y_neg_q, y_neg_d;
  logic                  x_major_q, x_major_d;
  color_t                color_q, color_d;
  logic                  active_q, active_d;

  logic signed [COORD_BITS:0] dx, dy;
  coord_t                ld_abs_dx, ld_abs_dy;
  logic                  ld_x_major;
  logic [ERR_BITS-1:0]   ld_err;

  coord_t                major_cur;
  logic                  is_last;
  logic                  err_pos;
  logic                  step_x, step_y;
  coord_t                major_abs, minor_abs;
  logic [ERR_BITS-1:0]   step_err;
  logic                  is_load, is_step;

  assign is_load = acc_i && (cmd_i.func == FUNC_LOAD);
  assign is_step = acc_i && (cmd_i.func == FUNC_STEP) && active_q;

  // Load setup: direction, extents, major axis, initial error.
  always_comb begin
    dx = $signed({cmd_i.end_x[COORD_BITS-1], cmd_i.end_x})
       - $signed({cmd_i.start_x[COORD_BITS-1], cmd_i.start_x});
    dy = $signed({cmd_i.end_y[COORD_BITS-1], cmd_i.end_y})
       - $signed({cmd_i.start_y[COORD_BITS-1], cmd_i.start_y});
    ld_abs_dx  = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ld_abs_dy  = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    ld_x_major = ld_abs_dx >= ld_abs_dy;
    if (ld_x_major) begin
      ld_err = {2'b00, ld_abs_dy} - {3'b000, ld_abs_dx[COORD_BITS-1:1]};
    end else begin
      ld_err = {2'b00, ld_abs_dx} - {3'b000, ld_abs_dy[COORD_BITS-1:1]};
    end
  end

  // Step: emit current pixel, then advance.
  always_comb begin
    major_cur = x_major_q ? cur_x_q : cur_y_q;
    is_last   = major_cur == major_end_q;
    err_pos   = !err_q[ERR_BITS-1] && (err_q != '0);
    major_abs = x_major_q ? abs_dx_q : abs_dy_q;
    minor_abs = x_major_q ? abs_dy_q : abs_dx_q;
    step_x    = x_major_q || err_pos;
    step_y    = !x_major_q || err_pos;
    step_err  = err_q - (err_pos ? {2'b00, major_abs} : '0) + {2'b00, minor_abs};
  end

  always_comb begin
    res_valid_o       = is_step;
    res_o.pixel_x     = cur_x_q;
    res_o.pixel_y     = cur_y_q;
    res_o.pixel_color = color_q;
    res_o.inside_res  = !cur_x_q[COORD_BITS-1] && (cur_x_q < screen_w_i)
                     && !cur_y_q[COORD_BITS-1] && (cur_y_q < screen_h_i);
    res_o.last        = is_last;
  end

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    major_end_d = major_end_q;
    abs_dx_d    = abs_dx_q;
    abs_dy_d    = abs_dy_q;
    err_d       = err_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    x_major_d   = x_major_q;
    color_d     = color_q;
    active_d    = active_q;
    if (is_load) begin
      cur_x_d     = cmd_i.start_x;
      cur_y_d     = cmd_i.start_y;
      major_end_d = ld_x_major ? cmd_i.end_x : cmd_i.end_y;
      abs_dx_d    = ld_abs_dx;
      abs_dy_d    = ld_abs_dy;
      err_d       = ld_err;
      x_neg_d     = dx[COORD_BITS];
      y_neg_d     = dy[COORD_BITS];
      x_major_d   = ld_x_major;
      color_d     = cmd_i.line_color;
      active_d    = 1'b1;
    end else if (is_step) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        if (step_x) begin
          cur_x_d = x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
        end
        if (step_y) begin
          cur_y_d = y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
        end
        err_d = step_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      major_end_q <= '0;
      abs_dx_q    <= '0;
      abs_dy_q    <= '0;
      err_q       <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      x_major_q   <= 1'b0;
      color_q     <= '0;
      active_q    <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      major_end_q <= major_end_d;
      abs_dx_q    <= abs_dx_d;
      abs_dy_q    <= abs_dy_d;
      err_q       <= err_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      x_major_q   <= x_major_d;
      color_q     <= color_d;
      active_q    <= active_d;
    end
  end

  a_load_starts_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> active_q)
    else $error("line not active after load");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_step && is_last) |=> !active_q)
    else $error("line still active after last pixel");

  a_idle_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_i && cmd_i.func == FUNC_STEP && !active_q)
      |=> ($stable(cur_x_q) && $stable(cur_y_q) && $stable(err_q) && !active_q))
    else $error("step without a line changed state");

  a_err_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (err_q[ERR_BITS-1] == err_q[ERR_BITS-2]))
    else $error("error term out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb_line_pixel_rasterizer_top.sv -----
// Testbench for the line pixel rasterizer: line predictor, pixel checks, random stream traffic.
`timescale 1ns / 1ps

module tb_line_pixel_rasterizer_top;
  import lpr_pkg::*;

  localparam int          COORD_MIN   = -(2 ** (COORD_BITS - 1));
  localparam int          COORD_MAX   = (2 ** (COORD_BITS - 1)) - 1;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_QUOTA = 130;

  // Predicts the pixels of the line being walked and holds those not yet seen.
  class line_tracker;
    logic [REG_BITS-1:0] scr_width;
    logic [REG_BITS-1:0] scr_height;
    int          pos_x, pos_y, major_stop, span_x, span_y, err_acc;
    bit          x_back, y_back, x_major, drawing;
    color_t      ink;
    pixel_t      pixels_due[$];
    int unsigned n_errors, n_pixels, n_inside, n_ends, n_loads;

    function new();
      scr_width  = SCREEN_WIDTH_RST;
      scr_height = SCREEN_HEIGHT_RST;
      pos_x      = 0;
      pos_y      = 0;
      major_stop = 0;
      span_x     = 0;
      span_y     = 0;
      err_acc    = 0;
      x_back     = 1'b0;
      y_back     = 1'b0;
      x_major    = 1'b0;
      drawing    = 1'b0;
      ink        = '0;
      n_errors   = 0;
      n_pixels   = 0;
      n_inside   = 0;
      n_ends     = 0;
      n_loads    = 0;
    endfunction

    static function int wrap_coord(int v);
      coord_t c;
      c = coord_t'(v);
      return int'($signed(c));
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [REG_BITS-1:0] val);
      case (idx)
        REG_SCREEN_WIDTH:  scr_width  = val;
        REG_SCREEN_HEIGHT: scr_height = val;
        default: ;
      endcase
    endfunction

    function void take_cmd(line_cmd_t cmd);
      int     x0, y0, x1, y1, dx, dy;
      pixel_t px;
      if (cmd.func == FUNC_LOAD) begin
        x0      = int'($signed(cmd.start_x));
        y0      = int'($signed(cmd.start_y));
        x1      = int'($signed(cmd.end_x));
        y1      = int'($signed(cmd.end_y));
        dx      = x1 - x0;
        dy      = y1 - y0;
        x_back  = dx < 0;
        y_back  = dy < 0;
        span_x  = x_back ? -dx : dx;
        span_y  = y_back ? -dy : dy;
        x_major = span_x >= span_y;
        if (x_major) begin
          err_acc    = span_y - span_x / 2;
          major_stop = x1;
        end else begin
          err_acc    = span_x - span_y / 2;
          major_stop = y1;
        end
        pos_x   = x0;
        pos_y   = y0;
        ink     = cmd.line_color;
        drawing = 1'b1;
        n_loads++;
        return;
      end
      // a step with no line in progress is dropped by the block
      if (!drawing) return;
      px.pixel_x     = coord_t'(pos_x);
      px.pixel_y     = coord_t'(pos_y);
      px.pixel_color = ink;
      px.inside_res  = pos_x >= 0 && pos_x < int'(scr_width) &&
                       pos_y >= 0 && pos_y < int'(scr_height);
      px.last        = (x_major ? pos_x : pos_y) == major_stop;
      pixels_due.push_back(px);
      if (px.last) begin
        drawing = 1'b0;
        return;
      end
      if (x_major) begin
        if (err_acc > 0) begin
          pos_y   = wrap_coord(pos_y + (y_back ? -1 : 1));
          err_acc -= span_x;
        end
        pos_x   = wrap_coord(pos_x + (x_back ? -1 : 1));
        err_acc += span_y;
      end else begin
        if (err_acc > 0) begin
          pos_x   = wrap_coord(pos_x + (x_back ? -1 : 1));
          err_acc -= span_y;
        end
        pos_y   = wrap_coord(pos_y + (y_back ? -1 : 1));
        err_acc += span_x;
      end
    endfunction

    function void match_pixel(pixel_t got);
      pixel_t want;
      if (pixels_due.size() == 0) begin
        $error("pixel with none expected: x=%0d y=%0d",
               $signed(got.pixel_x), $signed(got.pixel_y));
        n_errors++;
        return;
      end
      want = pixels_due.pop_front();
      n_pixels++;
      if (want.inside_res) n_inside++;
      if (want.last) n_ends++;
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", $signed(want.pixel_x), $signed(got.pixel_x));
        n_errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", $signed(want.pixel_y), $signed(got.pixel_y));
        n_errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color: expected 0x%0h, got 0x%0h", want.pixel_color, got.pixel_color);
        n_errors++;
      end
      if (got.inside_res !== want.inside_res) begin
        $error("inside_res: expected %0b, got %0b", want.inside_res, got.inside_res);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        n_errors++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [REG_BITS-1:0]      cfg_wdata_i;

  line_tracker tracker = new();
  line_cmd_t   seen_cmd;
  pixel_t      seen_pix;
  bit          calm;
  int unsigned hold_req;
  int unsigned cycle_cnt;
  int unsigned stall_cnt;
  int unsigned n_settings;

  line_pixel_rasterizer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (s_axis_tvalid && !s_axis_tready) stall_cnt <= stall_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_cnt, tracker.pending());
      $display("FAIL line_pixel_rasterizer_top");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      seen_cmd.func       = func_e'(s_axis_tuser);
      seen_cmd.start_x    = s_axis_tdata[0 +: COORD_BITS];
      seen_cmd.start_y    = s_axis_tdata[COORD_BITS +: COORD_BITS];
      seen_cmd.end_x      = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
      seen_cmd.end_y      = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
      seen_cmd.line_color = s_axis_tdata[4*COORD_BITS +: COLOR_BITS];
      tracker.take_cmd(seen_cmd);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      seen_pix.pixel_x     = m_axis_tdata[0 +: COORD_BITS];
      seen_pix.pixel_y     = m_axis_tdata[COORD_BITS +: COORD_BITS];
      seen_pix.pixel_color = m_axis_tdata[2*COORD_BITS +: COLOR_BITS];
      seen_pix.inside_res  = m_axis_tuser;
      seen_pix.last        = m_axis_tlast;
      tracker.match_pixel(seen_pix);
    end
  end

  // Pixel sink: random stalls, ready stretches, and one long hold-off on request.
  initial begin : pixel_sink
    int unsigned n;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req != 0) begin
        n             = hold_req;
        hold_req      = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v < COORD_MIN) return COORD_MIN;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic int rnd_coord();
    coord_t c;
    c = coord_t'($urandom());
    return int'($signed(c));
  endfunction

  function automatic int span_of(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_item(input func_e f, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey, input color_t col);
    maybe_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= IN_DATA_BITS'({col, ey, ex, sy, sx});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_line(input int x0, input int y0, input int x1, input int y1,
                           input color_t col);
    send_item(FUNC_LOAD, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1), col);
  endtask

  // Step with random payload; the block ignores it but the bits still toggle.
  task automatic step_pixel();
    send_item(FUNC_STEP, coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
              coord_t'($urandom()), color_t'($urandom()));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // let the monitor take the last accepted item before looking at the queue
    @(posedge clk_i);
    while (tracker.pending() != 0 || m_axis_tvalid) @(posedge clk_i);
    // a trailing load leaves no pixel behind, so give it time to settle
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_screen(input logic [REG_BITS-1:0] w, input logic [REG_BITS-1:0] h);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_SCREEN_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SCREEN_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_reg(REG_SCREEN_WIDTH, w);
    tracker.set_reg(REG_SCREEN_HEIGHT, h);
    n_settings++;
  endtask

  task automatic draw_lines(input int unsigned quota, input bit with_long);
    int unsigned taken;
    int          x0, y0, x1, y1, reach, n_steps, pick, spread;
    bit          long_one;
    taken    = 0;
    long_one = with_long;
    while (taken < quota) begin
      if (long_one) begin
        x0 = rnd_coord();
        y0 = rnd_coord();
        x1 = rnd_coord();
        y1 = rnd_coord();
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          x0 = clamp_coord(int'($urandom_range(0, tracker.scr_width + 8)) - 4);
          y0 = clamp_coord(int'($urandom_range(0, tracker.scr_height + 8)) - 4);
        end else begin
          x0 = rnd_coord();
          y0 = rnd_coord();
        end
        spread = ($urandom_range(0, 29) == 0) ? 300 : 8;
        x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * spread)) - spread);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * spread)) - spread);
      end
      load_line(x0, y0, x1, y1, color_t'($urandom()));
      taken++;
      reach = span_of(x0, x1);
      if (span_of(y0, y1) > reach) reach = span_of(y0, y1);
      reach++;
      pick = $urandom_range(0, 9);
      if (long_one || pick < 7) n_steps = reach;
      else if (pick < 9) n_steps = $urandom_range(0, reach - 1);
      else n_steps = 0;
      // keep each phase near its item budget; a cut line is replaced by the next load
      if (n_steps > int'(quota - taken)) n_steps = int'(quota - taken);
      repeat (n_steps) step_pixel();
      taken += n_steps;
      // steps after the line has ended give nothing
      if (n_steps == reach && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) step_pixel();
      long_one = 1'b0;
    end
  endtask

  task automatic run_phase(input logic [REG_BITS-1:0] w, input logic [REG_BITS-1:0] h,
                           input bit with_long, input int unsigned hold_len);
    write_screen(w, h);
    hold_req = hold_len;
    draw_lines(PHASE_QUOTA, with_long);
  endtask

  initial begin
    calm          = 1'b0;
    hold_req      = 0;
    cycle_cnt     = 0;
    stall_cnt     = 0;
    n_settings    = 1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_wdata_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed lines on the reset screen of 320 x 240
    step_pixel();
    load_line(0, 0, 0, 0, 16'h0000);
    step_pixel();
    load_line(319, 239, 320, 240, 16'hFFFF);
    repeat (2) step_pixel();
    load_line(-1, -1, -3, -2, 16'h1234);
    repeat (3) step_pixel();
    load_line(5, 5, 4, 9, 16'hA5A5);
    repeat (2) step_pixel();
    // reload mid-line at the coordinate extremes
    load_line(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 16'hFFFF);
    repeat (2) step_pixel();
    load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 16'h5A5A);
    step_pixel();
    load_line(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000);
    step_pixel();
    step_pixel();

    run_phase(12'd1, 12'd2048, 1'b0, 0);
    run_phase(12'd2048, 12'd1, 1'b1, 0);
    // hold the sink off long enough for the input to back up
    run_phase(12'd0, 12'd4095, 1'b0, 400);
    run_phase(REG_BITS'($urandom_range(1, 2048)), REG_BITS'($urandom_range(1, 2048)), 1'b0, 0);
    run_phase(12'd4095, 12'd0, 1'b1, 0);
    calm = 1'b1;
    run_phase(REG_BITS'($urandom_range(1, 64)), REG_BITS'($urandom_range(1, 64)), 1'b0, 0);

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d pixels (%0d on screen, %0d line ends) from %0d line loads",
             tracker.n_pixels, tracker.n_inside, tracker.n_ends, tracker.n_loads);
    $display("over %0d screen settings, %0d cycles of input back-pressure",
             n_settings, stall_cnt);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("PASS line_pixel_rasterizer_top");
    end else begin
      $display("FAIL line_pixel_rasterizer_top");
    end
    $finish;
  end

endmodule
